>>> design/lna_pkg.sv
// ----------------------------------------------------------------------------
// Landmark association package
// Shared widths, function and config codes, commands and status between
// controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package lna_pkg;
    localparam int MapDepth      = 1024;
    localparam int FrameFeatures = 64;
    localparam int MapAw         = $clog2(MapDepth);
    localparam int PendAw        = $clog2(FrameFeatures);
    localparam int FillW         = MapAw + 1;
    localparam int PendW         = PendAw + 1;
    localparam int CoordW        = 24;
    localparam int DistW         = 2 * (CoordW + 1) + 1;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_FEAT  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_GATE   = 1'b1;

    typedef struct packed {
        logic start_scan;   // begin landmark sweep (start or feature)
        logic start_flush;  // begin pending flush (end)
        logic start_div;    // begin rate division
        logic finish;       // commit item, load output register
    } lna_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic flush_done;
        logic div_done;
    } lna_sts_t;
endpackage
`default_nettype wire

>>> design/lna_ctrl.sv
// ----------------------------------------------------------------------------
// Landmark association controller
// Sequences one item at a time through scan, flush and divide steps.
// ----------------------------------------------------------------------------
`default_nettype none
module lna_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_fire,
    input  wire logic [1:0]      in_func,
    input  wire logic            out_free,
    input  wire lna_pkg::lna_sts_t sts,
    output lna_pkg::lna_cmd_t    cmd,
    output logic                 busy
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_func == lna_pkg::FUNC_START || in_func == lna_pkg::FUNC_FEAT) begin
                        cmd.start_scan = 1'b1;
                        state_next = S_SCAN;
                    end else if (in_func == lna_pkg::FUNC_END) begin
                        cmd.start_flush = 1'b1;
                        state_next = S_FLUSH;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: if (sts.scan_done) state_next = S_DONE;
            S_FLUSH: begin
                if (sts.flush_done) begin
                    cmd.start_div = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: if (sts.div_done) state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_fire_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> state_reg == S_IDLE) else $error("accept while busy");
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> out_free) else $error("finish into full output");
    a_div_after_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_div |-> state_reg == S_FLUSH) else $error("divide out of order");
`endif
endmodule
`default_nettype wire

>>> design/lna_dp.sv
// ----------------------------------------------------------------------------
// Landmark association datapath
// Landmark and pending memories, pipelined distance sweep, flush, divider.
// ----------------------------------------------------------------------------
`default_nettype none
module lna_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_fire,
    input  wire logic [1:0]        in_func,
    input  wire logic signed [23:0] in_ax,
    input  wire logic signed [23:0] in_ay,
    input  wire logic [15:0]       radius,
    input  wire logic [15:0]       gate,
    input  wire lna_pkg::lna_cmd_t cmd,
    output lna_pkg::lna_sts_t      sts,
    output logic [1:0]             r_kind,
    output logic [10:0]            r_match,
    output logic [15:0]            r_hits,
    output logic [6:0]             r_det,
    output logic [10:0]            r_exp,
    output logic [15:0]            r_rate,
    output logic [10:0]            r_map,
    output logic                   r_drop
);
    localparam int AW = lna_pkg::MapAw;
    localparam int FW = lna_pkg::FillW;
    localparam int PA = lna_pkg::PendAw;
    localparam int PW = lna_pkg::PendW;
    localparam int DW = lna_pkg::DistW;

    logic signed [23:0] lm_x [lna_pkg::MapDepth];
    logic signed [23:0] lm_y [lna_pkg::MapDepth];
    logic [15:0]        lm_c [lna_pkg::MapDepth];
    logic signed [23:0] pd_x [lna_pkg::FrameFeatures];
    logic signed [23:0] pd_y [lna_pkg::FrameFeatures];

    logic [FW-1:0] map_fill_reg;
    logic [PW-1:0] pend_fill_reg;
    logic [6:0]    det_reg;
    logic [10:0]   exp_reg;

    logic [1:0]         func_reg;
    logic signed [23:0] ax_reg, ay_reg;
    logic [DW-1:0]      thr_reg;

    // sweep: stage0 address, stage1 read data, stage2 squares, stage3 compare
    logic [FW-1:0]      addr_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]      i1_reg, i2_reg, i3_reg;
    logic signed [23:0] rx_reg, ry_reg;
    logic [DW-2:0]      sx_reg, sy_reg;
    logic [DW-1:0]      d3_reg;
    logic [DW-1:0]      best_reg;
    logic [AW-1:0]      bi_reg;
    logic               found_reg;
    logic [10:0]        cnt_reg;
    logic               scanning_reg;
    logic [15:0]        rc_reg;
    logic               upd_reg;
    logic               drop_reg;

    // flush
    logic               flushing_reg;
    logic [PW-1:0]      fidx_reg;
    logic               fv_reg;
    logic signed [23:0] fx_reg, fy_reg;

    // divider
    logic [15:0] quo_reg;
    logic [11:0] rem_reg;
    logic [14:0] num_reg;
    logic [4:0]  dcnt_reg;
    logic        div_run_reg, div_done_reg;

    logic signed [24:0]   dx, dy;
    logic signed [DW-2:0] px, py;
    logic                 lm_valid;
    logic [DW-1:0]        dsum;
    logic [11:0]          rtrial;

    assign dx = 25'(rx_reg) - 25'(ax_reg);
    assign dy = 25'(ry_reg) - 25'(ay_reg);
    assign px = dx * dx;
    assign py = dy * dy;
    assign lm_valid = addr_reg < map_fill_reg;
    assign dsum = DW'(sx_reg) + DW'(sy_reg);

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func_reg <= in_func;
            ax_reg   <= in_ax;
            ay_reg   <= in_ay;
            thr_reg  <= (in_func == lna_pkg::FUNC_START) ? DW'(32'(radius) * 32'(radius))
                                                          : DW'(32'(gate) * 32'(gate));
        end
    end

    always_ff @(posedge aclk) begin
        rx_reg <= lm_x[addr_reg[AW-1:0]];
        ry_reg <= lm_y[addr_reg[AW-1:0]];
        i1_reg <= addr_reg[AW-1:0];
        i2_reg <= i1_reg;
        i3_reg <= i2_reg;
        sx_reg <= $unsigned(px);
        sy_reg <= $unsigned(py);
        d3_reg <= dsum;
        rc_reg <= lm_c[bi_reg];
        fx_reg <= pd_x[fidx_reg[PA-1:0]];
        fy_reg <= pd_y[fidx_reg[PA-1:0]];
        if (upd_reg)
            lm_c[bi_reg] <= (rc_reg == 16'hFFFF) ? rc_reg : rc_reg + 16'd1;
        if (fv_reg && map_fill_reg < FW'(lna_pkg::MapDepth)) begin
            lm_x[map_fill_reg[AW-1:0]] <= fx_reg;
            lm_y[map_fill_reg[AW-1:0]] <= fy_reg;
            lm_c[map_fill_reg[AW-1:0]] <= 16'd1;
        end
        if (cmd.finish && func_reg == lna_pkg::FUNC_FEAT && !found_reg &&
            pend_fill_reg < PW'(lna_pkg::FrameFeatures)) begin
            pd_x[pend_fill_reg[PA-1:0]] <= ax_reg;
            pd_y[pend_fill_reg[PA-1:0]] <= ay_reg;
        end
    end

    assign rtrial = {rem_reg[10:0], num_reg[14]} - {1'b0, exp_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_fill_reg <= '0; pend_fill_reg <= '0; det_reg <= '0; exp_reg <= '0;
            scanning_reg <= 1'b0; v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            flushing_reg <= 1'b0; fv_reg <= 1'b0; upd_reg <= 1'b0;
            div_run_reg <= 1'b0; div_done_reg <= 1'b0; found_reg <= 1'b0;
            addr_reg <= '0; fidx_reg <= '0; drop_reg <= 1'b0;
        end else begin
            upd_reg <= 1'b0;
            div_done_reg <= 1'b0;
            if (cmd.start_scan) begin
                scanning_reg <= 1'b1;
                addr_reg <= '0;
                found_reg <= 1'b0;
                cnt_reg <= '0;
                best_reg <= (in_func == lna_pkg::FUNC_START) ? DW'(32'(radius) * 32'(radius))
                                                               : DW'(32'(gate) * 32'(gate));
            end else if (scanning_reg && lm_valid) begin
                addr_reg <= addr_reg + FW'(1);
            end
            v1_reg <= scanning_reg && lm_valid && !cmd.start_scan;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg) begin
                if (func_reg == lna_pkg::FUNC_START) begin
                    if (d3_reg < thr_reg && cnt_reg != 11'h7FF) cnt_reg <= cnt_reg + 11'd1;
                end else if (d3_reg < best_reg) begin
                    best_reg <= d3_reg; bi_reg <= i3_reg; found_reg <= 1'b1;
                end
            end
            if (scanning_reg && !lm_valid && !v1_reg && !v2_reg && !v3_reg &&
                !cmd.start_scan) begin
                scanning_reg <= 1'b0;
                if (func_reg == lna_pkg::FUNC_FEAT && found_reg) upd_reg <= 1'b1;
            end

            if (cmd.start_flush) begin
                flushing_reg <= 1'b1; fidx_reg <= '0; drop_reg <= 1'b0;
            end else if (flushing_reg) begin
                if (fidx_reg < pend_fill_reg) fidx_reg <= fidx_reg + PW'(1);
                else flushing_reg <= 1'b0;
            end
            fv_reg <= flushing_reg && fidx_reg < pend_fill_reg;
            if (fv_reg) begin
                if (map_fill_reg < FW'(lna_pkg::MapDepth)) map_fill_reg <= map_fill_reg + FW'(1);
                else drop_reg <= 1'b1;
            end

            if (cmd.start_div) begin
                div_run_reg <= 1'b1; dcnt_reg <= 5'd14;
                num_reg <= {det_reg, 8'd0}; rem_reg <= '0; quo_reg <= '0;
            end else if (div_run_reg) begin
                if (!rtrial[11]) rem_reg <= rtrial;
                else rem_reg <= {rem_reg[10:0], num_reg[14]};
                quo_reg <= {quo_reg[14:0], ~rtrial[11]};
                num_reg <= {num_reg[13:0], 1'b0};
                dcnt_reg <= dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd0) begin div_run_reg <= 1'b0; div_done_reg <= 1'b1; end
            end

            if (cmd.finish) begin
                r_kind <= func_reg;
                r_match <= 11'h7FF; r_hits <= '0; r_rate <= '0; r_drop <= 1'b0;
                case (func_reg)
                    lna_pkg::FUNC_START: begin
                        exp_reg <= cnt_reg; det_reg <= '0; pend_fill_reg <= '0;
                        r_det <= '0; r_exp <= cnt_reg;
                        r_map <= 11'(map_fill_reg);
                    end
                    lna_pkg::FUNC_FEAT: begin
                        r_exp <= exp_reg; r_map <= 11'(map_fill_reg);
                        if (found_reg) begin
                            r_match <= 11'(bi_reg);
                            r_hits <= rc_reg;
                            det_reg <= (det_reg == 7'h7F) ? det_reg : det_reg + 7'd1;
                            r_det <= (det_reg == 7'h7F) ? det_reg : det_reg + 7'd1;
                        end else begin
                            r_det <= det_reg;
                            if (pend_fill_reg < PW'(lna_pkg::FrameFeatures))
                                pend_fill_reg <= pend_fill_reg + PW'(1);
                            else r_drop <= 1'b1;
                        end
                    end
                    lna_pkg::FUNC_END: begin
                        pend_fill_reg <= '0;
                        r_det <= det_reg; r_exp <= exp_reg; r_map <= 11'(map_fill_reg);
                        r_drop <= drop_reg;
                        r_rate <= (exp_reg == '0) ? 16'd256 : quo_reg;
                    end
                    default: begin
                        r_det <= det_reg; r_exp <= exp_reg; r_map <= 11'(map_fill_reg);
                    end
                endcase
            end
        end
    end

    // scan_done held low while upd is set so rc_reg carries fresh count before finish
    assign sts.scan_done  = !scanning_reg && !cmd.start_scan && !upd_reg;
    assign sts.flush_done = !flushing_reg && !fv_reg && !cmd.start_flush;
    assign sts.div_done   = div_done_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        map_fill_reg <= FW'(lna_pkg::MapDepth)) else $error("map fill overrun");
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_fill_reg <= PW'(lna_pkg::FrameFeatures)) else $error("pending overrun");
    a_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> $past(v2_reg)) else $error("sweep pipe broken");
`endif
endmodule
`default_nettype wire

>>> design/landmark_nearest_association.sv
// ----------------------------------------------------------------------------
// Landmark nearest association
// Gated nearest-neighbor association against a planar landmark map.
// ----------------------------------------------------------------------------
// Input stream s_axis: frame start, feature or frame end; one result per item
// on m_axis. Config channel cfg writes radius (index 0) and gate (index 1).
// One item at a time. A frame start or feature sweeps every stored landmark
// through a four-stage distance pipeline; a matching feature also updates
// that landmark's hit count before the result. A frame end copies the
// pending buffer into the map, then runs a 15-step restoring divider for the
// rate. s_axis_tready is low while an item is in work; the result waits in
// the output register while m_axis_tready is low, and the next item may be
// accepted while it waits, but its own result is held until the output
// register is free. Reset empties the map and pending buffer and restores
// register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module landmark_nearest_association (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // car_x, car_y, feat_x, feat_y
    input  wire logic [1:0]  s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // match_index, landmark_hits, num_detected,
                                            // num_expected, rep_rate, map_size, dropped
    output logic [1:0]       m_axis_tuser,  // kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [15:0] radius_reg, gate_reg;
    logic        busy, in_fire, out_free, mvalid_reg;
    lna_pkg::lna_cmd_t cmd;
    lna_pkg::lna_sts_t sts;
    logic signed [23:0] ax, ay;
    logic [1:0]  r_kind;
    logic [10:0] r_match, r_exp, r_map;
    logic [15:0] r_hits, r_rate;
    logic [6:0]  r_det;
    logic        r_drop;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !mvalid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;
    assign ax = (s_axis_tuser == lna_pkg::FUNC_START) ? s_axis_tdata[23:0] : s_axis_tdata[71:48];
    assign ay = (s_axis_tuser == lna_pkg::FUNC_START) ? s_axis_tdata[47:24] : s_axis_tdata[95:72];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 16'd12800; gate_reg <= 16'd512; mvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == lna_pkg::CFG_RADIUS) radius_reg <= cfg_data;
                else gate_reg <= cfg_data;
            end
            if (cmd.finish) mvalid_reg <= 1'b1;
            else if (m_axis_tready) mvalid_reg <= 1'b0;
        end
    end

    lna_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .in_func(s_axis_tuser), .out_free,
        .sts, .cmd, .busy
    );

    lna_dp u_dp (
        .aclk, .aresetn, .in_fire, .in_func(s_axis_tuser), .in_ax(ax), .in_ay(ay),
        .radius(radius_reg), .gate(gate_reg), .cmd, .sts,
        .r_kind, .r_match, .r_hits, .r_det, .r_exp, .r_rate, .r_map, .r_drop
    );

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tdata  = {7'd0, r_drop, r_map, r_rate, r_exp, r_det, r_hits, r_match};
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Landmark association testbench
// Drives frame start, feature and frame end transfers into the association
// block, predicts every result from an internal map model and compares each
// result transfer field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [10:0] match_index;
        logic [15:0]        landmark_hits;
        logic [6:0]         num_detected;
        logic [10:0]        num_expected;
        logic [15:0]        rep_rate;
        logic [10:0]        map_size;
        logic               dropped;
    } assoc_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;  // car_x, car_y, feat_x, feat_y
    logic [1:0]  s_axis_tuser = '0;  // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;       // match_index, landmark_hits, num_detected,
                                     // num_expected, rep_rate, map_size, dropped
    logic [1:0]  m_axis_tuser;       // kind
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    landmark_nearest_association dut (.*);

    // predictor state
    logic [15:0]        radius_q, gate_q;
    logic signed [23:0] lm_x [lna_pkg::MapDepth];
    logic signed [23:0] lm_y [lna_pkg::MapDepth];
    logic [15:0]        lm_hits [lna_pkg::MapDepth];
    int unsigned        lm_fill;
    logic signed [23:0] pend_x [lna_pkg::FrameFeatures];
    logic signed [23:0] pend_y [lna_pkg::FrameFeatures];
    int unsigned        pend_fill, det_cnt, exp_cnt;

    assoc_res_t  expected_q [$];
    int          errors = 0;
    int unsigned burst_left = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [49:0] sq_dist(logic signed [23:0] ax, logic signed [23:0] ay,
                                            logic signed [23:0] bx, logic signed [23:0] by);
        logic signed [49:0] dx, dy;
        dx = 50'(ax) - 50'(bx);
        dy = 50'(ay) - 50'(by);
        return $unsigned(dx * dx) + $unsigned(dy * dy);
    endfunction

    function automatic assoc_res_t associate(logic [1:0] func, logic signed [23:0] cx,
                                             logic signed [23:0] cy, logic signed [23:0] fx,
                                             logic signed [23:0] fy);
        assoc_res_t r;
        logic [49:0] lim, d;
        int          bi, n;
        logic [31:0] q;
        r = '0;
        r.kind = func;
        r.match_index = -11'sd1;
        bi = -1;
        case (func)
            lna_pkg::FUNC_START: begin
                lim = 50'(radius_q) * 50'(radius_q);
                n = 0;
                for (int i = 0; i < lm_fill; i++)
                    if (sq_dist(cx, cy, lm_x[i], lm_y[i]) < lim && n < 2047) n++;
                exp_cnt = n;
                det_cnt = 0;
                pend_fill = 0;
            end
            lna_pkg::FUNC_FEAT: begin
                lim = 50'(gate_q) * 50'(gate_q);
                for (int i = 0; i < lm_fill; i++) begin
                    d = sq_dist(fx, fy, lm_x[i], lm_y[i]);
                    if (d < lim) begin
                        lim = d;
                        bi = i;
                    end
                end
                if (bi >= 0) begin
                    if (lm_hits[bi] != 16'hffff) lm_hits[bi]++;
                    r.landmark_hits = lm_hits[bi];
                    r.match_index = 11'(bi);
                    if (det_cnt < 127) det_cnt++;
                end else if (pend_fill < lna_pkg::FrameFeatures) begin
                    pend_x[pend_fill] = fx;
                    pend_y[pend_fill] = fy;
                    pend_fill++;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            lna_pkg::FUNC_END: begin
                if (exp_cnt == 0) r.rep_rate = 16'd256;
                else begin
                    q = (det_cnt << 8) / exp_cnt;
                    r.rep_rate = q > 65535 ? 16'hffff : q[15:0];
                end
                for (int i = 0; i < pend_fill; i++) begin
                    if (lm_fill < lna_pkg::MapDepth) begin
                        lm_x[lm_fill] = pend_x[i];
                        lm_y[lm_fill] = pend_y[i];
                        lm_hits[lm_fill] = 16'd1;
                        lm_fill++;
                    end else r.dropped = 1'b1;
                end
                pend_fill = 0;
            end
            default: ;
        endcase
        r.num_detected = 7'(det_cnt);
        r.num_expected = 11'(exp_cnt);
        r.map_size = 11'(lm_fill);
        return r;
    endfunction

    task automatic send_item(logic [1:0] func, logic signed [23:0] cx, logic signed [23:0] cy,
                             logic signed [23:0] fx, logic signed [23:0] fy);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {fy, fx, cy, cx};
        expected_q.insert(expected_q.size(), associate(func, cx, cy, fx, fy));
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == lna_pkg::CFG_RADIUS) radius_q = val;
        else gate_q = val;
        @(posedge aclk);
    endtask

    function automatic logic signed [23:0] near(logic signed [23:0] c, int spread);
        return c + 24'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // frame of features near existing landmarks and fresh points
    task automatic run_frame(int nfeat, logic signed [23:0] ox, logic signed [23:0] oy,
                             int spread);
        int k;
        send_item(lna_pkg::FUNC_START, near(ox, spread), near(oy, spread),
                  24'($urandom), 24'($urandom));
        for (int i = 0; i < nfeat; i++) begin
            if (lm_fill > 0 && $urandom_range(0, 1)) begin
                k = $urandom_range(0, lm_fill - 1);
                send_item(lna_pkg::FUNC_FEAT, 24'($urandom), 24'($urandom),
                          near(lm_x[k], 600), near(lm_y[k], 600));
            end else
                send_item(lna_pkg::FUNC_FEAT, 24'($urandom), 24'($urandom),
                          near(ox, spread), near(oy, spread));
        end
        send_item(lna_pkg::FUNC_END, 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom));
    endtask

    task automatic test_directed();
        send_item(lna_pkg::FUNC_END, 24'h7fffff, 24'h800000, 24'h0, 24'h0); // end without start
        send_item(lna_pkg::FUNC_FEAT, 24'h0, 24'h0, 24'h800000, 24'h7fffff); // empty map
        send_item(lna_pkg::FUNC_START, 24'h800000, 24'h7fffff, 24'h0, 24'h0);
        send_item(lna_pkg::FUNC_FEAT, 24'h0, 24'h0, 24'h800000, 24'h800000);
        send_item(lna_pkg::FUNC_FEAT, 24'h0, 24'h0, 24'h7fffff, 24'h7fffff);
        send_item(lna_pkg::FUNC_FEAT, 24'h0, 24'h0, 24'h100, 24'h100);
        send_item(lna_pkg::FUNC_FEAT, 24'h0, 24'h0, 24'h300, 24'h100);
        send_item(lna_pkg::FUNC_END, 24'h0, 24'h0, 24'h0, 24'h0);
        send_item(lna_pkg::FUNC_START, 24'h200, 24'h100, 24'h0, 24'h0);
        send_item(lna_pkg::FUNC_FEAT, 24'h0, 24'h0, 24'h200, 24'h100);     // tie between two
        send_item(lna_pkg::FUNC_FEAT, 24'h0, 24'h0, 24'h7fff00, 24'h7fffff);
        send_item(FUNC_SPARE, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
        send_item(lna_pkg::FUNC_END, 24'h0, 24'h0, 24'h0, 24'h0);
        send_item(lna_pkg::FUNC_FEAT, 24'h0, 24'h0, 24'h100, 24'h100);     // outside a frame
        send_item(lna_pkg::FUNC_END, 24'h0, 24'h0, 24'h0, 24'h0);
    endtask

    task automatic test_buffer_full();
        send_item(lna_pkg::FUNC_START, 24'h0, 24'h0, 24'h0, 24'h0);
        for (int i = 0; i < lna_pkg::FrameFeatures + 3; i++)
            send_item(lna_pkg::FUNC_FEAT, 24'h0, 24'h0, 24'(-2000000 + i * 3000), 24'h400000);
        send_item(lna_pkg::FUNC_START, 24'h0, 24'h0, 24'h0, 24'h0);        // discards buffer
        send_item(lna_pkg::FUNC_END, 24'h0, 24'h0, 24'h0, 24'h0);
    endtask

    task automatic test_registers();
        go_idle();
        write_reg(lna_pkg::CFG_RADIUS, 16'hffff);
        write_reg(lna_pkg::CFG_GATE, 16'hffff);
        run_frame(6, 24'h0, 24'h0, 4000);
        go_idle();
        write_reg(lna_pkg::CFG_RADIUS, 16'h0);
        write_reg(lna_pkg::CFG_GATE, 16'h0);
        run_frame(4, 24'h1000, 24'h1000, 4000);
        go_idle();
        write_reg(lna_pkg::CFG_RADIUS, 16'd12800);
        write_reg(lna_pkg::CFG_GATE, 16'd512);
    endtask

    task automatic test_random(int nitems);
        int sent;
        int nf;
        sent = 0;
        while (sent < nitems) begin
            nf = $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0)
                send_item(2'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 24'($urandom));
            else
                run_frame(nf, 24'($signed($urandom_range(0, 20000)) - 10000),
                          24'($signed($urandom_range(0, 20000)) - 10000),
                          $urandom_range(0, 3) == 0 ? 8000000 : 5000);
            sent += nf + 2;
            if ($urandom_range(0, 40) == 0) begin
                go_idle();
                write_reg(lna_pkg::CFG_RADIUS, 16'($urandom));
                write_reg(lna_pkg::CFG_GATE, 16'($urandom_range(0, 2000)));
            end
        end
    endtask

    // result side: stall pattern plus checking
    initial begin
        assoc_res_t got, exp_r;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind          = m_axis_tuser;
                got.match_index   = m_axis_tdata[10:0];
                got.landmark_hits = m_axis_tdata[26:11];
                got.num_detected  = m_axis_tdata[33:27];
                got.num_expected  = m_axis_tdata[44:34];
                got.rep_rate      = m_axis_tdata[60:45];
                got.map_size      = m_axis_tdata[71:61];
                got.dropped       = m_axis_tdata[72];
                if (expected_q.size() == 0) begin
                    $error("unexpected result transfer");
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.kind != exp_r.kind) begin
                        $error("kind exp %0d got %0d", exp_r.kind, got.kind); errors++;
                    end
                    if (got.match_index != exp_r.match_index) begin
                        $error("match_index exp %0d got %0d", exp_r.match_index,
                               got.match_index); errors++;
                    end
                    if (got.landmark_hits != exp_r.landmark_hits) begin
                        $error("landmark_hits exp %0d got %0d", exp_r.landmark_hits,
                               got.landmark_hits); errors++;
                    end
                    if (got.num_detected != exp_r.num_detected) begin
                        $error("num_detected exp %0d got %0d", exp_r.num_detected,
                               got.num_detected); errors++;
                    end
                    if (got.num_expected != exp_r.num_expected) begin
                        $error("num_expected exp %0d got %0d", exp_r.num_expected,
                               got.num_expected); errors++;
                    end
                    if (got.rep_rate != exp_r.rep_rate) begin
                        $error("rep_rate exp %0d got %0d", exp_r.rep_rate, got.rep_rate);
                        errors++;
                    end
                    if (got.map_size != exp_r.map_size) begin
                        $error("map_size exp %0d got %0d", exp_r.map_size, got.map_size);
                        errors++;
                    end
                    if (got.dropped != exp_r.dropped) begin
                        $error("dropped exp %0d got %0d", exp_r.dropped, got.dropped);
                        errors++;
                    end
                end
            end
            if (aresetn) m_axis_tready <= ($time / 4000) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        radius_q = 16'd12800;
        gate_q = 16'd512;
        lm_fill = 0;
        pend_fill = 0;
        det_cnt = 0;
        exp_cnt = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_buffer_full();
        test_registers();
        test_random(480);
        go_idle();
        if (errors == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

>>> landmark_nearest_association.f
design/lna_pkg.sv
design/lna_ctrl.sv
design/lna_dp.sv
design/landmark_nearest_association.sv
tb/sv/tb.sv
